// File: hdl/pvae_pkg.sv
// Package with the shared widths and types of the pose rate estimator.
`timescale 1ns / 1ps
`default_nettype none
package pvae_pkg;

  // Width of the signed difference fed into the rate unit.
  localparam int unsigned NUM_W  = 33;
  // Width of the ticks-per-second register.
  localparam int unsigned TPS_W  = 30;
  // Width of the magnitude product of a difference and ticks per second.
  localparam int unsigned PROD_W = NUM_W + TPS_W;
  // Width of one rate.
  localparam int unsigned RATE_W = 32;
  // Number of rates per result.
  localparam int unsigned N_RATES = 6;

  // Reset value of ticks per second.
  localparam logic [TPS_W-1:0] TPS_RESET = TPS_W'(1000000);

  // Register indexes of the configuration port.
  localparam logic REG_TPS = 1'b0;

  typedef logic signed [RATE_W-1:0] rate_t;

  // Handshake between the sequencer and the rate unit.
  typedef struct packed {
    logic start;
  } md_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } md_rsp_t;

endpackage
`default_nettype wire

// File: hdl/pvae_rate_unit.sv
// Bit-serial multiply and restoring divide unit producing one saturated rate.
`timescale 1ns / 1ps
`default_nettype none
module pvae_rate_unit import pvae_pkg::*; #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire md_req_t                      req_i,
  input  wire logic signed [NUM_W-1:0]      num_i,
  input  wire logic signed [TIME_WIDTH-1:0] dt_i,
  input  wire logic [TPS_W-1:0]             tps_i,
  output md_rsp_t                           rsp_o,
  output rate_t                             rate_o
);

  localparam int unsigned CNT_W = $clog2(PROD_W + 1);

  typedef enum logic [2:0] {
    MD_IDLE = 3'b001,
    MD_MUL  = 3'b010,
    MD_DIV  = 3'b100
  } md_state_e;

  md_state_e               state_q;
  logic [CNT_W-1:0]        cnt_q;
  logic [NUM_W-1:0]        mcand_q;
  logic [TPS_W-1:0]        mplier_q;
  logic [PROD_W-1:0]       acc_q;
  logic [TIME_WIDTH-1:0]   dmag_q;
  logic [TIME_WIDTH-1:0]   rem_q;
  logic                    neg_q;
  logic                    done_q;
  rate_t                   rate_q;

  logic [NUM_W-1:0]        num_mag;
  logic [TIME_WIDTH-1:0]   dt_mag;
  logic [PROD_W-1:0]       acc_add;
  logic [TIME_WIDTH:0]     rem_sh;
  logic                    fits;
  logic [PROD_W-1:0]       q_fin;
  rate_t                   sat;

  // Operand magnitudes at start.
  assign num_mag = num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
  assign dt_mag  = dt_i[TIME_WIDTH-1] ? TIME_WIDTH'(-dt_i) : TIME_WIDTH'(dt_i);

  // One multiply step, most significant multiplier bit first.
  assign acc_add = {acc_q[PROD_W-2:0], 1'b0}
                 + (mplier_q[TPS_W-1] ? PROD_W'(mcand_q) : '0);

  // One restoring divide step.
  assign rem_sh = {rem_q, acc_q[PROD_W-1]};
  assign fits   = rem_sh >= {1'b0, dmag_q};

  // Quotient of the final step, then sign and saturation.
  assign q_fin = {acc_q[PROD_W-2:0], fits};
  always_comb begin
    if (neg_q) begin
      if (q_fin > PROD_W'(64'h8000_0000)) begin
        sat = {1'b1, {(RATE_W-1){1'b0}}};
      end else begin
        sat = rate_t'(-q_fin[RATE_W-1:0]);
      end
    end else begin
      if (q_fin > PROD_W'(64'h7FFF_FFFF)) begin
        sat = {1'b0, {(RATE_W-1){1'b1}}};
      end else begin
        sat = rate_t'(q_fin[RATE_W-1:0]);
      end
    end
  end

  // Sequencing of the multiply and divide passes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= MD_IDLE;
      cnt_q    <= '0;
      done_q   <= 1'b0;
      mcand_q  <= '0;
      mplier_q <= '0;
      acc_q    <= '0;
      dmag_q   <= '0;
      rem_q    <= '0;
      neg_q    <= 1'b0;
      rate_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        MD_IDLE: begin
          if (req_i.start) begin
            mcand_q  <= num_mag;
            mplier_q <= tps_i;
            dmag_q   <= dt_mag;
            neg_q    <= num_i[NUM_W-1] ^ dt_i[TIME_WIDTH-1];
            acc_q    <= '0;
            cnt_q    <= CNT_W'(TPS_W - 1);
            state_q  <= MD_MUL;
          end
        end
        MD_MUL: begin
          acc_q    <= acc_add;
          mplier_q <= {mplier_q[TPS_W-2:0], 1'b0};
          if (cnt_q == '0) begin
            rem_q   <= '0;
            cnt_q   <= CNT_W'(PROD_W - 1);
            state_q <= MD_DIV;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        MD_DIV: begin
          rem_q <= fits ? TIME_WIDTH'(rem_sh - {1'b0, dmag_q}) : rem_sh[TIME_WIDTH-1:0];
          acc_q <= q_fin;
          if (cnt_q == '0) begin
            rate_q  <= sat;
            done_q  <= 1'b1;
            state_q <= MD_IDLE;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        default: state_q <= MD_IDLE;
      endcase
    end
  end

  assign rsp_o.busy = state_q != MD_IDLE;
  assign rsp_o.done = done_q;
  assign rate_o     = rate_q;

endmodule
`default_nettype wire

// File: hdl/pose_velocity_acceleration_estimator.sv
// Top level: pose history, request sequencer, output register and register port.
// A request that is lost, first or with zero elapsed time goes straight to the
// output register; otherwise the single bit-serial rate unit computes six rates
// in turn, with 30 multiply steps and 63 divide steps per rate.
// A new request is taken once the previous one has moved into the output register.
// Reset is asynchronous and active low; it clears history and rates and loads
// ticks per second with one million.
`timescale 1ns / 1ps
`default_nettype none
module pose_velocity_acceleration_estimator import pvae_pkg::*; #(
  parameter int unsigned POS_WIDTH   = 32,
  parameter int unsigned ANGLE_WIDTH = 16,
  parameter int unsigned TIME_WIDTH  = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // Configuration port.
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [2:0]             paddr,
  input  wire logic [31:0]            pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // Request channel.
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic                   present_i,
  input  wire logic [POS_WIDTH-1:0]   pos_x_i,
  input  wire logic [POS_WIDTH-1:0]   pos_y_i,
  input  wire logic [ANGLE_WIDTH-1:0] heading_i,
  input  wire logic [TIME_WIDTH-1:0]  timestamp_i,
  // Result channel.
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic                        result_valid_o,
  output logic [31:0]                 out_x_o,
  output logic [31:0]                 out_y_o,
  output logic [15:0]                 out_heading_o,
  output logic [31:0]                 vel_x_o,
  output logic [31:0]                 vel_y_o,
  output logic [31:0]                 ang_vel_o,
  output logic [31:0]                 acc_x_o,
  output logic [31:0]                 acc_y_o,
  output logic [31:0]                 ang_acc_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e                     state_q;
  logic [TPS_W-1:0]           tps_q;
  logic                       hist_q;
  logic                       lost_q;
  logic [TIME_WIDTH-1:0]      last_t_q;
  logic [POS_WIDTH-1:0]       last_x_q;
  logic [POS_WIDTH-1:0]       last_y_q;
  logic [ANGLE_WIDTH-1:0]     last_h_q;
  rate_t                      rates_q [N_RATES];
  rate_t                      new_q   [N_RATES];
  logic signed [NUM_W-1:0]    dx_q;
  logic signed [NUM_W-1:0]    dy_q;
  logic signed [NUM_W-1:0]    dh_q;
  logic signed [TIME_WIDTH-1:0] dt_q;
  logic [2:0]                 op_q;
  logic                       start_q;

  logic                       out_valid_q;
  logic                       res_valid_q;
  logic [31:0]                ox_q;
  logic [31:0]                oy_q;
  logic [15:0]                oh_q;
  rate_t                      orates_q [N_RATES];

  logic                       in_acc;
  logic                       cfg_wr;
  logic                       out_free;
  logic signed [TIME_WIDTH-1:0] dt_in;
  logic signed [POS_WIDTH:0]  dx_in;
  logic signed [POS_WIDTH:0]  dy_in;
  logic [ANGLE_WIDTH-1:0]     dh_in;
  logic [1:0]                 aidx;
  logic signed [NUM_W-1:0]    num;
  md_req_t                    md_req;
  md_rsp_t                    md_rsp;
  rate_t                      md_rate;
  logic [31:0]                h_ext;

  // Register port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TPS);
  assign prdata = (paddr[2] == REG_TPS) ? 32'(tps_q) : '0;

  // Request handshake and differences against the history.
  assign in_ready_o = state_q == ST_IDLE;
  assign in_acc     = in_valid_i && in_ready_o;
  assign dt_in      = TIME_WIDTH'(timestamp_i - last_t_q);
  assign dx_in      = (POS_WIDTH+1)'($signed(pos_x_i)) - (POS_WIDTH+1)'($signed(last_x_q));
  assign dy_in      = (POS_WIDTH+1)'($signed(pos_y_i)) - (POS_WIDTH+1)'($signed(last_y_q));
  assign dh_in      = heading_i - last_h_q;

  // Operand selection: pose differences first, then velocity differences.
  assign aidx = 2'(op_q - 3'd3);
  always_comb begin
    unique case (op_q)
      3'd0:    num = dx_q;
      3'd1:    num = dy_q;
      3'd2:    num = dh_q;
      default: num = NUM_W'(new_q[aidx]) - NUM_W'(rates_q[aidx]);
    endcase
  end

  assign md_req.start = start_q;

  pvae_rate_unit #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_rate (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .num_i  (num),
    .dt_i   (dt_q),
    .tps_i  (tps_q),
    .rsp_o  (md_rsp),
    .rate_o (md_rate)
  );

  assign out_free = !out_valid_q || out_ready_i;
  assign h_ext    = 32'(last_h_q);

  // Sequencer, history and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tps_q       <= TPS_RESET;
      hist_q      <= 1'b0;
      lost_q      <= 1'b0;
      last_t_q    <= '0;
      last_x_q    <= '0;
      last_y_q    <= '0;
      last_h_q    <= '0;
      dx_q        <= '0;
      dy_q        <= '0;
      dh_q        <= '0;
      dt_q        <= '0;
      op_q        <= '0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
      ox_q        <= '0;
      oy_q        <= '0;
      oh_q        <= '0;
      for (int i = 0; i < N_RATES; i++) begin
        rates_q[i]  <= '0;
        new_q[i]    <= '0;
        orates_q[i] <= '0;
      end
    end else begin
      start_q <= 1'b0;
      if (cfg_wr) begin
        tps_q <= pwdata[TPS_W-1:0];
      end
      // The emit state refills the output register itself.
      if (out_valid_q && out_ready_i && state_q != ST_EMIT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            state_q <= ST_EMIT;
            lost_q  <= !present_i;
            if (!present_i) begin
              hist_q <= 1'b0;
            end else if (!hist_q || dt_in != '0) begin
              hist_q   <= 1'b1;
              last_t_q <= timestamp_i;
              last_x_q <= pos_x_i;
              last_y_q <= pos_y_i;
              last_h_q <= heading_i;
              dx_q     <= NUM_W'(dx_in);
              dy_q     <= NUM_W'(dy_in);
              dh_q     <= NUM_W'($signed(dh_in));
              dt_q     <= dt_in;
              if (!hist_q) begin
                for (int i = 0; i < N_RATES; i++) begin
                  rates_q[i] <= '0;
                end
              end else begin
                op_q    <= '0;
                start_q <= 1'b1;
                state_q <= ST_RUN;
              end
            end
          end
        end
        ST_RUN: begin
          if (md_rsp.done) begin
            new_q[op_q] <= md_rate;
            if (op_q == 3'(N_RATES - 1)) begin
              for (int i = 0; i < N_RATES - 1; i++) begin
                rates_q[i] <= new_q[i];
              end
              rates_q[N_RATES-1] <= md_rate;
              state_q <= ST_EMIT;
            end else begin
              op_q    <= op_q + 1'b1;
              start_q <= 1'b1;
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            res_valid_q <= !lost_q;
            ox_q        <= lost_q ? '0 : 32'($signed(last_x_q));
            oy_q        <= lost_q ? '0 : 32'($signed(last_y_q));
            oh_q        <= lost_q ? '0 : h_ext[15:0];
            for (int i = 0; i < N_RATES; i++) begin
              orates_q[i] <= lost_q ? '0 : rates_q[i];
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_valid_o = res_valid_q;
  assign out_x_o        = ox_q;
  assign out_y_o        = oy_q;
  assign out_heading_o  = oh_q;
  assign vel_x_o        = orates_q[0];
  assign vel_y_o        = orates_q[1];
  assign ang_vel_o      = orates_q[2];
  assign acc_x_o        = orates_q[3];
  assign acc_y_o        = orates_q[4];
  assign ang_acc_o      = orates_q[5];

  // The rate unit is idle whenever a new request may enter.
  a_idle_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !md_rsp.busy)
    else $error("rate unit busy while accepting a request");

  // A finished rate only arrives while the sequencer is running.
  a_done_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_rsp.done |-> state_q == ST_RUN)
    else $error("rate finished outside the run state");

  // A lost-object result carries no rates; x velocity, angular velocity, y and angular acceleration are checked.
  a_lost_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !result_valid_o) |->
      (vel_x_o == '0 && ang_vel_o == '0 && acc_y_o == '0 && ang_acc_o == '0))
    else $error("lost result with non-zero rates");

  // The operation counter never passes the last rate.
  a_op_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |-> op_q < 3'(N_RATES))
    else $error("operation counter out of range");

endmodule
`default_nettype wire
